[design/rst_pkg.sv]
// Shared types and constants for the running sigma threshold block.
// Used by rst_iter and running_sigma_threshold; no dependencies.
package rst_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 24;

    // Shift-subtract unit sizes
    localparam int OPERAND_W = 64;
    localparam int STEP_W    = 7;
    localparam int REM_W     = 36;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [15:0] WARMUP_RST    = 16'd50;
    localparam logic [23:0] INIT_SPEC_RST = 24'd76800;
    localparam logic [7:0]  SIGMA_K_RST   = 8'd48;
    localparam logic [23:0] MIN_SIGMA_RST = 24'd256;

    localparam logic [23:0] MAX24 = 24'hFFFFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WARMUP    = 2'd0,
        REG_INIT_SPEC = 2'd1,
        REG_SIGMA_K   = 2'd2,
        REG_MIN_SIGMA = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        ITER_DIV  = 1'b0,
        ITER_SQRT = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic             start;
        iter_mode_t       mode;
        logic [STEP_W-1:0] steps;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

[design/rst_iter.sv]
// Shared shift-subtract unit: restoring division or square root, one bit per cycle.
// Depends on rst_pkg.
module rst_iter
    import rst_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  iter_cmd_t            cmd,
    input  logic [OPERAND_W-1:0] operand,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output iter_stat_t           stat,
    output logic [OPERAND_W-1:0] result
);

    logic                   busy_reg;
    logic                   done_reg;
    iter_mode_t             mode_reg;
    logic [STEP_W-1:0]      cnt_reg;
    logic [OPERAND_W-1:0]   work_reg;
    logic [OPERAND_W-1:0]   res_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [COUNT_WIDTH-1:0] div_reg;

    logic [REM_W-1:0] a_op;
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             ge;

    always_comb begin
        unique case (mode_reg)
            ITER_DIV: begin
                a_op  = {rem_reg[REM_W-2:0], work_reg[OPERAND_W-1]};
                trial = REM_W'(div_reg);
            end
            ITER_SQRT: begin
                a_op  = {rem_reg[REM_W-3:0], work_reg[OPERAND_W-1 -: 2]};
                trial = {res_reg[REM_W-3:0], 2'b01};
            end
            default: begin
                a_op  = '0;
                trial = '0;
            end
        endcase
        diff = {1'b0, a_op} - {1'b0, trial};
        ge   = ~diff[REM_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= ITER_DIV;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start && !busy_reg) begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.mode;
                cnt_reg  <= cmd.steps;
                work_reg <= operand;
                div_reg  <= divisor;
                res_reg  <= '0;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[REM_W-1:0] : a_op;
                res_reg <= {res_reg[OPERAND_W-2:0], ge};
                if (mode_reg == ITER_SQRT) begin
                    work_reg <= {work_reg[OPERAND_W-3:0], 2'b00};
                end else begin
                    work_reg <= {work_reg[OPERAND_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule

[design/running_sigma_threshold.sv]
// Running mean / sigma with outlier threshold, top level and sequencer.
// Depends on rst_pkg and rst_iter.
//
// Each accepted sample updates count, Welford mean and M2, then reports sigma and a
// threshold (fixed initial_spec during warm-up, else mean + k * max(sigma, min)).
// One sample is handled at a time; s_tready is low while it is worked on, and the
// next sample is accepted only once the result has gone into the output register.
// The time per sample is set by the shared shift-subtract unit: one quotient bit
// per cycle for the mean division and the M2/(n-1) division, one root bit per cycle
// for the square root.
// When sigma is zero (first sample, or M2 not positive) the last two passes are
// skipped. The result sits in an output register, so the handshake on m_ can stall
// without losing the beat.
module running_sigma_threshold
    import rst_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [SAMPLE_WIDTH-1:0] sample
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [23:0] count_seen, [55:24] mean_out, [79:56] sigma_out, [108:80] threshold_out
    output logic [111:0]              m_tdata,
    // [0] warming_up
    output logic                      m_tuser
);

    localparam int XQ_W    = SAMPLE_WIDTH + 16;
    localparam int DMAG_W  = (XQ_W > 32) ? XQ_W : 32;
    localparam int MW      = DMAG_W + 2;
    localparam int AB_W    = DMAG_W - 8;
    localparam int PROD_W  = 2 * AB_W;
    localparam int CMP_W   = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int CO_W    = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_DIV1, S_D2, S_MUL, S_ACC, S_SIG, S_DIV2, S_SQRT,
        S_KMUL, S_OUT
    } state_t;

    state_t                   state_reg;
    logic [15:0]              warmup_reg;
    logic [23:0]              init_spec_reg;
    logic [7:0]               sigma_k_reg;
    logic [23:0]              min_sigma_reg;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [31:0]              mean_reg;
    logic signed [63:0]       m2_reg;
    logic [SAMPLE_WIDTH-1:0]  x_reg;
    logic [DMAG_W-1:0]        dmag_reg;
    logic                     dneg_reg;
    logic [DMAG_W-1:0]        d2mag_reg;
    logic                     d2neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [23:0]              sigma_reg;
    logic [31:0]              kprod_reg;
    logic                     m_tvalid_reg;
    logic [111:0]             m_tdata_reg;
    logic                     m_tuser_reg;

    iter_cmd_t                iter_cmd;
    iter_stat_t               iter_stat;
    logic [OPERAND_W-1:0]     iter_op;
    logic [COUNT_WIDTH-1:0]   iter_divisor;
    logic [OPERAND_W-1:0]     iter_res;

    rst_iter #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (iter_cmd),
        .operand (iter_op),
        .divisor (iter_divisor),
        .stat    (iter_stat),
        .result  (iter_res)
    );

    // Datapath terms
    logic signed [MW-1:0] xq_s;
    logic signed [MW-1:0] mean_s;
    logic signed [MW-1:0] d_s;
    logic [DMAG_W-1:0]    dmag_c;
    logic signed [MW-1:0] q_s;
    logic signed [MW-1:0] mnew_s;
    logic [31:0]          mnew_clamped;
    logic [63:0]          p64;
    logic [63:0]          p_sat;
    logic signed [65:0]   m2_sum;
    logic [63:0]          m2_new;
    logic [31:0]          root;
    logic [23:0]          sigma_t;
    logic [36:0]          thr_sum;
    logic                 warm;
    logic [CO_W-1:0]      cnt_ext;
    logic [23:0]          cnt_out;
    logic                 out_free;

    always_comb begin
        xq_s   = MW'({x_reg, 16'b0});
        mean_s = MW'(mean_reg);
        d_s    = xq_s - mean_s;
        dmag_c = d_s[MW-1] ? DMAG_W'(-d_s) : d_s[DMAG_W-1:0];
        q_s    = MW'(iter_res[DMAG_W-1:0]);
        mnew_s = dneg_reg ? (mean_s - q_s) : (mean_s + q_s);
        if (mnew_s[MW-1]) begin
            mnew_clamped = '0;
        end else if (|mnew_s[MW-2:32]) begin
            mnew_clamped = 32'hFFFFFFFF;
        end else begin
            mnew_clamped = mnew_s[31:0];
        end

        p64   = 64'(prod_reg);
        p_sat = p64[63] ? 64'h7FFFFFFFFFFFFFFF : p64;
        if (dneg_reg != d2neg_reg) begin
            m2_sum = 66'(m2_reg) - $signed({2'b00, p_sat});
        end else begin
            m2_sum = 66'(m2_reg) + $signed({2'b00, p_sat});
        end
        if (m2_sum[65:63] == 3'b000 || m2_sum[65:63] == 3'b111) begin
            m2_new = m2_sum[63:0];
        end else if (m2_sum[65]) begin
            m2_new = 64'h8000000000000000;
        end else begin
            m2_new = 64'h7FFFFFFFFFFFFFFF;
        end

        root    = iter_res[31:0];
        sigma_t = (sigma_reg < min_sigma_reg) ? min_sigma_reg : sigma_reg;
        thr_sum = {5'b0, mean_reg} + {1'b0, kprod_reg, 4'b0};
        warm    = CMP_W'(count_reg) < CMP_W'(warmup_reg);
        cnt_ext = CO_W'(count_reg);
        cnt_out = (cnt_ext > CO_W'(MAX24)) ? MAX24 : cnt_ext[23:0];
        out_free = !m_tvalid_reg || m_tready;
    end

    always_comb begin
        iter_cmd.start = 1'b0;
        iter_cmd.mode  = ITER_DIV;
        iter_cmd.steps = STEP_W'(DMAG_W);
        iter_op        = {dmag_reg, {(OPERAND_W-DMAG_W){1'b0}}};
        iter_divisor   = count_reg;
        unique case (state_reg)
            S_DIFF: begin
                // the difference magnitude is taken before the division starts
                iter_cmd.start = 1'b1;
                iter_op        = {dmag_c, {(OPERAND_W-DMAG_W){1'b0}}};
            end
            S_SIG: begin
                iter_cmd.start = (count_reg > COUNT_WIDTH'(1)) && (m2_reg > 64'sd0);
                iter_cmd.steps = STEP_W'(OPERAND_W);
                iter_op        = m2_reg;
                iter_divisor   = count_reg - 1'b1;
            end
            S_DIV2: begin
                iter_cmd.start = iter_stat.done;
                iter_cmd.mode  = ITER_SQRT;
                iter_cmd.steps = STEP_W'(OPERAND_W / 2);
                iter_op        = iter_res;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            warmup_reg    <= WARMUP_RST;
            init_spec_reg <= INIT_SPEC_RST;
            sigma_k_reg   <= SIGMA_K_RST;
            min_sigma_reg <= MIN_SIGMA_RST;
            count_reg     <= '0;
            mean_reg      <= '0;
            m2_reg        <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_WARMUP:    warmup_reg    <= cfg_wr_data[15:0];
                    REG_INIT_SPEC: init_spec_reg <= cfg_wr_data;
                    REG_SIGMA_K:   sigma_k_reg   <= cfg_wr_data[7:0];
                    REG_MIN_SIGMA: min_sigma_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg <= s_tdata[SAMPLE_WIDTH-1:0];
                        if (count_reg != {COUNT_WIDTH{1'b1}}) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    dneg_reg  <= d_s[MW-1];
                    dmag_reg  <= dmag_c;
                    state_reg <= S_DIV1;
                end
                S_DIV1: begin
                    if (iter_stat.done) begin
                        mean_reg  <= mnew_clamped;
                        state_reg <= S_D2;
                    end
                end
                S_D2: begin
                    d2neg_reg <= d_s[MW-1];
                    d2mag_reg <= dmag_c;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= dmag_reg[DMAG_W-1:8] * d2mag_reg[DMAG_W-1:8];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    m2_reg    <= m2_new;
                    state_reg <= S_SIG;
                end
                S_SIG: begin
                    if (iter_cmd.start) begin
                        state_reg <= S_DIV2;
                    end else begin
                        sigma_reg <= '0;
                        state_reg <= S_KMUL;
                    end
                end
                S_DIV2: begin
                    if (iter_stat.done) begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (iter_stat.done) begin
                        sigma_reg <= (root > 32'(MAX24)) ? MAX24 : root[23:0];
                        state_reg <= S_KMUL;
                    end
                end
                S_KMUL: begin
                    kprod_reg <= sigma_k_reg * sigma_t;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= {3'b000,
                                         warm ? {5'b0, init_spec_reg} : thr_sum[36:8],
                                         sigma_reg, mean_reg, cnt_out};
                        m_tuser_reg  <= warm;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_ready_unit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !iter_stat.busy)
        else $error("input ready while shared unit busy");

    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_stat.done |-> $past(iter_stat.busy))
        else $error("shared unit done without running");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_DIFF))
        else $error("accepted beat did not start work");
`endif

endmodule

[test/tb_top.sv]
// Self-checking bench for running_sigma_threshold: random samples, stalls, config phases.
// Depends on rst_pkg and the running_sigma_threshold RTL.
module tb_top
    import rst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        warm;
        logic [28:0] thr;
        logic [23:0] sigma;
        logic [31:0] mean;
        logic [23:0] cnt;
    } stat_beat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [15:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic m_tuser;

    running_sigma_threshold dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state and registers
    logic [15:0] warmup_q;
    logic [23:0] init_spec_q, min_sigma_q;
    logic [7:0] k_q;
    logic [23:0] n_q;
    logic [31:0] mean_q;
    longint m2_q;

    stat_beat_t expected_stats[$];
    logic [15:0] samples_pending[$];
    int errors = 0, beats_checked = 0, sent = 0;
    longint cycles = 0;
    bit hold_sender = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic stat_beat_t update_stats(logic [15:0] x);
        stat_beat_t r;
        longint xq, d, d2, mn;
        longint unsigned q, a, b, p, sg, st, th, n;
        xq = longint'(x) << 16;
        if (n_q != 24'hFFFFFF) n_q++;
        n = n_q;
        d = xq - longint'(mean_q);
        q = mag(d) / n;
        mn = d < 0 ? longint'(mean_q) - longint'(q) : longint'(mean_q) + longint'(q);
        if (mn < 0) mn = 0;
        if (mn > 64'hFFFFFFFF) mn = 64'hFFFFFFFF;
        mean_q = mn[31:0];
        d2 = xq - mn;
        a = mag(d) >> 8;
        b = mag(d2) >> 8;
        p = a * b;
        if (p > 64'h7FFFFFFFFFFFFFFF) p = 64'h7FFFFFFFFFFFFFFF;
        if ((d < 0) == (d2 < 0)) begin
            if (m2_q > 64'sh7FFFFFFFFFFFFFFF - longint'(p)) m2_q = 64'sh7FFFFFFFFFFFFFFF;
            else m2_q += longint'(p);
        end else begin
            if (m2_q < -64'sh7FFFFFFFFFFFFFFF - 1 + longint'(p))
                m2_q = -64'sh7FFFFFFFFFFFFFFF - 1;
            else m2_q -= longint'(p);
        end
        sg = 0;
        if (n > 1 && m2_q > 0) begin
            sg = root_floor(longint'(m2_q) / (n - 1));
            if (sg > 64'hFFFFFF) sg = 64'hFFFFFF;
        end
        r.warm = n < warmup_q;
        if (r.warm) begin
            th = init_spec_q;
        end else begin
            st = sg < min_sigma_q ? min_sigma_q : sg;
            th = (mean_q + ((k_q * st) << 4)) >> 8;
        end
        r.cnt = n_q;
        r.mean = mean_q;
        r.sigma = sg[23:0];
        r.thr = th[28:0];
        return r;
    endfunction

    // driver: present samples from the pending queue with random gaps
    int gap_left = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_stats.push_back(update_stats(s_tdata));
                sent <= sent + 1;
                void'(samples_pending.pop_front());
                gap_left <= $urandom_range(0, 4);
                s_tvalid <= 1'b0;
            end else if (!s_tvalid && !hold_sender && samples_pending.size() > 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else begin
                    s_tdata <= samples_pending[0];
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // monitor: random backpressure, compare each beat with the oldest prediction
    int stall_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                stat_beat_t got, want;
                got = {m_tuser, m_tdata[108:0]};
                beats_checked <= beats_checked + 1;
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_stats.pop_front();
                    if (got.cnt !== want.cnt || got.mean !== want.mean ||
                        got.sigma !== want.sigma || got.thr !== want.thr ||
                        got.warm !== want.warm) begin
                        $display("%0t: mismatch exp cnt=%0d mean=%h sigma=%h thr=%h warm=%b",
                                 $time, want.cnt, want.mean, want.sigma, want.thr, want.warm);
                        $display("%0t:          got cnt=%0d mean=%h sigma=%h thr=%h warm=%b",
                                 $time, got.cnt, got.mean, got.sigma, got.thr, got.warm);
                        errors <= errors + 1;
                    end
                end
                stall_left = $urandom_range(0, 4);
                m_tready <= (stall_left == 0);
            end else if (!m_tready) begin
                if (stall_left > 0) stall_left = stall_left - 1;
                m_tready <= (stall_left == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > 2_000_000) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_WARMUP:    warmup_q = val[15:0];
            REG_INIT_SPEC: init_spec_q = val;
            REG_SIGMA_K:   k_q = val[7:0];
            REG_MIN_SIGMA: min_sigma_q = val;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain;
        wait (samples_pending.size() == 0 && !s_tvalid);
        wait (expected_stats.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic push_random(int count, int span);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 3))
                0: samples_pending.push_back($urandom);
                1: samples_pending.push_back(16'd1000 + $urandom_range(0, span));
                2: samples_pending.push_back($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                default: samples_pending.push_back(16'd30000 + $urandom_range(0, span));
            endcase
        end
    endtask

    initial begin
        warmup_q = WARMUP_RST;
        init_spec_q = INIT_SPEC_RST;
        k_q = SIGMA_K_RST;
        min_sigma_q = MIN_SIGMA_RST;
        n_q = '0;
        mean_q = '0;
        m2_q = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;

        // directed: single sample, constant run (zero variance), extremes, alternation
        write_reg(REG_WARMUP, 24'd4);
        samples_pending.push_back(16'h0000);
        samples_pending.push_back(16'h0000);
        samples_pending.push_back(16'h0000);
        samples_pending.push_back(16'hFFFF);
        samples_pending.push_back(16'h0000);
        samples_pending.push_back(16'hFFFF);
        for (int i = 0; i < 16; i++) samples_pending.push_back(16'h1 << i);
        drain();

        // each phase: new register setting, then random samples
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_WARMUP, 24'd0);
                    write_reg(REG_SIGMA_K, 24'd255);
                    write_reg(REG_MIN_SIGMA, 24'hFFFFFF);
                    write_reg(REG_INIT_SPEC, 24'hFFFFFF);
                end
                1: begin
                    write_reg(REG_WARMUP, 24'hFFFF);
                    write_reg(REG_INIT_SPEC, 24'd0);
                end
                2: begin
                    write_reg(REG_WARMUP, 24'd100);
                    write_reg(REG_SIGMA_K, 24'd0);
                    write_reg(REG_MIN_SIGMA, 24'd0);
                end
                default: begin
                    write_reg(REG_WARMUP, $urandom_range(0, 300));
                    write_reg(REG_INIT_SPEC, $urandom_range(0, 24'hFFFFFF));
                    write_reg(REG_SIGMA_K, $urandom_range(0, 255));
                    write_reg(REG_MIN_SIGMA, $urandom_range(0, 24'hFFFF));
                end
            endcase
            push_random(120, ph * 2000 + 50);
            if (ph == 3) begin
                // pause the sender until everything outstanding has come back
                wait (samples_pending.size() < 60);
                hold_sender = 1'b1;
                wait (!s_tvalid && expected_stats.size() == 0);
                hold_sender = 1'b0;
            end
            drain();
        end

        $display("sent %0d samples over 7 register settings, %0d beats checked",
                 sent, beats_checked);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
